>>> hdl/cau_pkg.sv
// shared constants, types and helper functions for the complex arithmetic unit
// no dependencies; imported by every module of the block
package cau_pkg;

  localparam int DATA_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * DATA_BITS;
  localparam int WIDE_BITS = 2 * DATA_BITS + 1;
  localparam int QUOT_BITS = DATA_BITS + 1;
  localparam int NUMX_BITS = WIDE_BITS + FRAC_BITS;
  localparam int STEP_BITS = $clog2(DATA_BITS);
  localparam int LATENCY   = 2 * DATA_BITS + 6;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_CONJ  = 3'd4,
    OP_UNIT  = 3'd5,
    OP_SQMAG = 3'd6
  } op_t;

  typedef logic signed [DATA_BITS-1:0] data_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;

  typedef struct packed {
    logic                 valid;
    logic                 quot;
    logic                 unit;
    data_t                re;
    data_t                im;
    logic                 ovf;
    logic                 dz;
    wide_t                num_re;
    wide_t                num_im;
    logic [PROD_BITS-1:0] den;
  } cargo_t;

  typedef struct packed {
    cargo_t               c;
    logic [PROD_BITS-1:0] rad;
    logic [WIDE_BITS-1:0] root;
  } sq_t;

  typedef struct packed {
    logic                 neg;
    logic                 big;
    logic [WIDE_BITS-1:0] rem;
    logic [QUOT_BITS-1:0] low;
    logic [QUOT_BITS-1:0] q;
  } lane_t;

  typedef struct packed {
    logic                 valid;
    logic                 quot;
    logic                 zero;
    data_t                re;
    data_t                im;
    logic                 ovf;
    logic                 dz;
    logic [PROD_BITS-1:0] den;
    lane_t                lre;
    lane_t                lim;
  } dv_t;

  typedef struct packed {
    data_t val;
    logic  ovf;
  } sat_t;

  function automatic sat_t saturate(wide_t v);
    sat_t  r;
    wide_t hi;
    wide_t lo;
    hi = {{(WIDE_BITS-DATA_BITS+1){1'b0}}, {(DATA_BITS-1){1'b1}}};
    lo = {{(WIDE_BITS-DATA_BITS+1){1'b1}}, {(DATA_BITS-1){1'b0}}};
    if (v > hi) begin
      r.val = {1'b0, {(DATA_BITS-1){1'b1}}};
      r.ovf = 1'b1;
    end else if (v < lo) begin
      r.val = {1'b1, {(DATA_BITS-1){1'b0}}};
      r.ovf = 1'b1;
    end else begin
      r.val = v[DATA_BITS-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // add half an lsb, then arithmetic shift: rounds half up
  function automatic wide_t round_frac(wide_t v);
    wide_t h;
    wide_t s;
    h = '0;
    h[FRAC_BITS-1] = 1'b1;
    s = v + h;
    return s >>> FRAC_BITS;
  endfunction

endpackage

>>> hdl/cau_front.sv
// front end: input register, six multipliers, and combine stage
// depends on cau_pkg; finishes add/sub/mul/conj/sqmag and sets up div and unit
module cau_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [2:0]                   op,
  input  cau_pkg::data_t               a_re,
  input  cau_pkg::data_t               a_im,
  input  cau_pkg::data_t               b_re,
  input  cau_pkg::data_t               b_im,
  output cau_pkg::cargo_t              out
);
  import cau_pkg::*;

  logic        v1;
  logic [2:0]  op1;
  data_t       ar1, ai1, br1, bi1;

  logic        v2;
  logic [2:0]  op2;
  data_t       ar2, ai2, br2, bi2;
  logic signed [PROD_BITS-1:0] p0, p1, p2, p3, p4, p5;

  data_t       sq_x, sq_y;
  logic        self_sq;
  cargo_t      out_next;

  // stage 1: capture the transaction
  always_ff @(posedge clk) begin
    v1  <= load && !rst;
    op1 <= op;
    ar1 <= a_re;
    ai1 <= a_im;
    br1 <= b_re;
    bi1 <= b_im;
  end

  // squares of a for unit and sqmag, of b for div
  assign self_sq = (op1 == OP_UNIT) || (op1 == OP_SQMAG);
  assign sq_x    = self_sq ? ar1 : br1;
  assign sq_y    = self_sq ? ai1 : bi1;

  // stage 2: products
  always_ff @(posedge clk) begin
    v2  <= v1 && !rst;
    op2 <= op1;
    ar2 <= ar1;
    ai2 <= ai1;
    br2 <= br1;
    bi2 <= bi1;
    p0  <= ar1 * br1;
    p1  <= ai1 * bi1;
    p2  <= ar1 * bi1;
    p3  <= ai1 * br1;
    p4  <= sq_x * sq_x;
    p5  <= sq_y * sq_y;
  end

  // stage 3: combine
  always_comb begin
    sat_t  sr;
    sat_t  si;
    wide_t sum_sq;
    sr = '0;
    si = '0;
    sum_sq = WIDE_BITS'(p4) + WIDE_BITS'(p5);
    out_next = '0;
    out_next.valid = v2 && !rst;
    case (op2)
      OP_ADD: begin
        sr = saturate(WIDE_BITS'(ar2) + WIDE_BITS'(br2));
        si = saturate(WIDE_BITS'(ai2) + WIDE_BITS'(bi2));
      end
      OP_SUB: begin
        sr = saturate(WIDE_BITS'(ar2) - WIDE_BITS'(br2));
        si = saturate(WIDE_BITS'(ai2) - WIDE_BITS'(bi2));
      end
      OP_MUL: begin
        sr = saturate(round_frac(WIDE_BITS'(p0) - WIDE_BITS'(p1)));
        si = saturate(round_frac(WIDE_BITS'(p2) + WIDE_BITS'(p3)));
      end
      OP_DIV: begin
        out_next.quot   = 1'b1;
        out_next.num_re = WIDE_BITS'(p0) + WIDE_BITS'(p1);
        out_next.num_im = WIDE_BITS'(p3) - WIDE_BITS'(p2);
        out_next.den    = sum_sq[PROD_BITS-1:0];
        out_next.dz     = (sum_sq == '0);
      end
      OP_CONJ: begin
        sr = saturate(WIDE_BITS'(ar2));
        si = saturate(-WIDE_BITS'(ai2));
      end
      OP_UNIT: begin
        out_next.quot   = 1'b1;
        out_next.unit   = 1'b1;
        out_next.num_re = WIDE_BITS'(ar2);
        out_next.num_im = WIDE_BITS'(ai2);
        out_next.den    = sum_sq[PROD_BITS-1:0];
      end
      OP_SQMAG: begin
        sr = saturate(round_frac(sum_sq));
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase
    out_next.re  = sr.val;
    out_next.im  = si.val;
    out_next.ovf = sr.ovf | si.ovf;
  end

  always_ff @(posedge clk) begin
    out <= out_next;
  end

endmodule

>>> hdl/cau_sqrt_step.sv
// one registered iteration of the integer square root (one root bit)
// depends on cau_pkg; chained in the top level, index picks the bit weight
module cau_sqrt_step (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [cau_pkg::STEP_BITS-1:0] idx,
  input  cau_pkg::sq_t                 d,
  output cau_pkg::sq_t                 q
);
  import cau_pkg::*;

  logic [WIDE_BITS-1:0] bit_w;
  logic [WIDE_BITS-1:0] trial;
  logic [WIDE_BITS-1:0] rad_w;
  logic                 ge;
  sq_t                  q_next;

  always_comb begin
    bit_w  = WIDE_BITS'(1) << {idx, 1'b0};
    trial  = d.root + bit_w;
    rad_w  = WIDE_BITS'(d.rad);
    ge     = rad_w >= trial;
    q_next = d;
    q_next.c.valid = d.c.valid && !rst;
    if (ge) begin
      q_next.rad  = PROD_BITS'(rad_w - trial);
      q_next.root = (d.root >> 1) + bit_w;
    end else begin
      q_next.root = d.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

>>> hdl/cau_div_step.sv
// one registered restoring-division step, one quotient bit for each lane
// depends on cau_pkg; chained in the top level
module cau_div_step (
  input  logic         clk,
  input  logic         rst,
  input  cau_pkg::dv_t d,
  output cau_pkg::dv_t q
);
  import cau_pkg::*;

  dv_t q_next;

  function automatic lane_t lane_step(lane_t l, logic [PROD_BITS-1:0] den);
    lane_t                r;
    logic [WIDE_BITS-1:0] r2;
    logic [WIDE_BITS-1:0] dw;
    logic                 ge;
    r  = l;
    dw = WIDE_BITS'(den);
    r2 = {l.rem[WIDE_BITS-2:0], l.low[QUOT_BITS-1]};
    ge = r2 >= dw;
    r.rem = ge ? (r2 - dw) : r2;
    r.low = l.low << 1;
    r.q   = {l.q[QUOT_BITS-2:0], ge};
    return r;
  endfunction

  always_comb begin
    q_next       = d;
    q_next.valid = d.valid && !rst;
    q_next.lre   = lane_step(d.lre, d.den);
    q_next.lim   = lane_step(d.lim, d.den);
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

>>> hdl/complex_arithmetic_unit.sv
// complex arithmetic unit top level: front end, root chain, divider setup, divider chain, output register
// throughput one transaction per cycle outside reset, set by the fully pipelined root and divider chains
// busy is high only while rst is high; results cannot be held off by the receiver
// rst (synchronous) clears every valid bit; payload registers are not reset
// depends on cau_pkg, cau_front, cau_sqrt_step, cau_div_step
module complex_arithmetic_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic [2:0]     op,
  input  cau_pkg::data_t a_re,
  input  cau_pkg::data_t a_im,
  input  cau_pkg::data_t b_re,
  input  cau_pkg::data_t b_im,
  output logic           done,
  output cau_pkg::data_t res_re,
  output cau_pkg::data_t res_im,
  output logic           overflow,
  output logic           div_zero
);
  import cau_pkg::*;

  // a new transaction may enter every cycle while rst is low; nothing stalls
  assign busy = rst;

  cargo_t front_out;
  sq_t    sq_pipe [DATA_BITS+1];
  dv_t    dv_pipe [QUOT_BITS+1];
  dv_t    setup_next;
  dv_t    dv_setup;
  cargo_t sq_c;
  logic [PROD_BITS-1:0] den_sel;

  // stages 1..3: operand capture, products, simple ops finished here
  cau_front u_front (
    .clk  (clk),
    .rst  (rst),
    .load (start && !busy),
    .op   (op),
    .a_re (a_re),
    .a_im (a_im),
    .b_re (b_re),
    .b_im (b_im),
    .out  (front_out)
  );

  // square root chain: one root bit per stage, only unit uses the root
  assign sq_pipe[0] = '{c: front_out, rad: front_out.den, root: '0};

  for (genvar k = 0; k < DATA_BITS; k++) begin : g_sqrt
    cau_sqrt_step u_sqrt (
      .clk (clk),
      .rst (rst),
      .idx (STEP_BITS'(DATA_BITS - 1 - k)),
      .d   (sq_pipe[k]),
      .q   (sq_pipe[k+1])
    );
  end

  // divider setup: pick denominator, split |num| << frac into top and low bits
  function automatic lane_t lane_init(wide_t num, logic [PROD_BITS-1:0] den);
    lane_t                r;
    logic [WIDE_BITS-1:0] mag;
    logic [NUMX_BITS-1:0] x;
    logic [NUMX_BITS-1:0] topx;
    mag   = num[WIDE_BITS-1] ? WIDE_BITS'(-num) : WIDE_BITS'(num);
    x     = NUMX_BITS'(mag) << FRAC_BITS;
    topx  = x >> QUOT_BITS;
    r.neg = num[WIDE_BITS-1];
    // quotient would not fit the step count: saturates anyway
    r.big = topx >= NUMX_BITS'(den);
    r.rem = topx[WIDE_BITS-1:0];
    r.low = x[QUOT_BITS-1:0];
    r.q   = '0;
    return r;
  endfunction

  assign sq_c    = sq_pipe[DATA_BITS].c;
  assign den_sel = sq_c.unit ? PROD_BITS'(sq_pipe[DATA_BITS].root[DATA_BITS-1:0]) : sq_c.den;

  always_comb begin
    setup_next.valid = sq_c.valid && !rst;
    setup_next.quot  = sq_c.quot;
    // zero divisor, or unit of zero: result is zero with no overflow
    setup_next.zero  = (den_sel == '0);
    setup_next.re    = sq_c.re;
    setup_next.im    = sq_c.im;
    setup_next.ovf   = sq_c.ovf;
    setup_next.dz    = sq_c.dz;
    setup_next.den   = den_sel;
    setup_next.lre   = lane_init(sq_c.num_re, den_sel);
    setup_next.lim   = lane_init(sq_c.num_im, den_sel);
  end

  always_ff @(posedge clk) begin
    dv_setup <= setup_next;
  end

  assign dv_pipe[0] = dv_setup;

  // divider chain: one quotient bit per stage, both lanes side by side
  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
    cau_div_step u_div (
      .clk (clk),
      .rst (rst),
      .d   (dv_pipe[k]),
      .q   (dv_pipe[k+1])
    );
  end

  // quotient magnitude to signed saturated result
  function automatic sat_t lane_finish(lane_t l);
    sat_t                 r;
    logic [QUOT_BITS-1:0] lim_pos;
    logic [QUOT_BITS-1:0] lim_neg;
    logic [DATA_BITS-1:0] qd;
    lim_pos = {2'b00, {(DATA_BITS-1){1'b1}}};
    lim_neg = {2'b01, {(DATA_BITS-1){1'b0}}};
    qd      = l.q[DATA_BITS-1:0];
    if (l.neg) begin
      r.ovf = l.big || (l.q > lim_neg);
      r.val = r.ovf ? {1'b1, {(DATA_BITS-1){1'b0}}} : -qd;
    end else begin
      r.ovf = l.big || (l.q > lim_pos);
      r.val = r.ovf ? {1'b0, {(DATA_BITS-1){1'b1}}} : qd;
    end
    return r;
  endfunction

  // output register: one strobe per transaction
  always_ff @(posedge clk) begin
    sat_t fr;
    sat_t fi;
    fr = lane_finish(dv_pipe[QUOT_BITS].lre);
    fi = lane_finish(dv_pipe[QUOT_BITS].lim);
    done     <= dv_pipe[QUOT_BITS].valid && !rst;
    div_zero <= dv_pipe[QUOT_BITS].dz;
    if (!dv_pipe[QUOT_BITS].quot) begin
      res_re   <= dv_pipe[QUOT_BITS].re;
      res_im   <= dv_pipe[QUOT_BITS].im;
      overflow <= dv_pipe[QUOT_BITS].ovf;
    end else if (dv_pipe[QUOT_BITS].zero) begin
      res_re   <= '0;
      res_im   <= '0;
      overflow <= 1'b0;
    end else begin
      res_re   <= fr.val;
      res_im   <= fi.val;
      overflow <= fr.ovf | fi.ovf;
    end
  end

  // every result traces back to an accepted transaction a fixed latency earlier
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching transaction");

  // a divide by zero comes out flagged with div_zero on its result strobe
  a_div_zero_timing: assert property (@(posedge clk) disable iff (rst)
    $past(start && !busy && (op == OP_DIV) && (b_re == '0) && (b_im == '0), LATENCY)
    |-> done && div_zero)
    else $error("zero divisor not flagged at the expected cycle");

  // zero divisor result is clean zero
  a_div_zero_clean: assert property (@(posedge clk) disable iff (rst)
    done && div_zero |-> (res_re == '0) && (res_im == '0) && !overflow)
    else $error("zero divisor result not zero");

  // strobe never comes out of reset
  a_no_done_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe right after reset");

endmodule
